// ===== rtl/core/bip_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bip_pkg: shared types and constants of the BCD IMU frame parser
// Frame layout, byte position decode and result record.
// ---------------------------------------------------------------------------
package bip_pkg;

  // Frame layout
  localparam int FRAME_LENGTH = 23;
  localparam int HDR_BYTES    = 4;
  localparam int VALUE_FIRST  = 4;
  localparam int AXES         = 6;
  localparam int VALUE_BYTES  = 3 * AXES;
  localparam int CNT_W        = 5;
  localparam int VAL_W        = 19;
  localparam int MAG_W        = 18;
  localparam int AXIS_W       = 3;

  // Header bytes and sign threshold
  localparam logic [7:0] HDR_B0   = 8'h77;
  localparam logic [7:0] HDR_B1   = 8'h16;
  localparam logic [7:0] HDR_B2   = 8'h00;
  localparam logic [7:0] HDR_B3   = 8'h84;
  localparam logic [7:0] NEG_MIN  = 8'h10;

  // Digit weights
  localparam logic [MAG_W-1:0] W_TOP = 18'd10000;
  localparam logic [14:0]      W_MID = 15'd100;

  // Byte phase within one three-byte value
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_MID  = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  // One accepted input transfer
  typedef struct packed {
    logic       frame_start;
    logic [7:0] rx_byte;
  } item_t;

  // What a byte position means
  typedef struct packed {
    logic              is_hdr;
    logic              is_val;
    phase_t            phase;
    logic [AXIS_W-1:0] axis;
  } pos_t;

  // Decoder status toward the top level
  typedef struct packed {
    logic             produces;
    logic [CNT_W-1:0] count;
  } dec_status_t;

  // One result transfer
  typedef struct packed {
    logic                    header_ok;
    logic signed [VAL_W-1:0] accel_z;
    logic signed [VAL_W-1:0] accel_y;
    logic signed [VAL_W-1:0] accel_x;
    logic signed [VAL_W-1:0] rate_z;
    logic signed [VAL_W-1:0] rate_y;
    logic signed [VAL_W-1:0] rate_x;
  } result_t;

  // Expected header byte at header position idx
  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      default: b = HDR_B3;
    endcase
    return b;
  endfunction

  // Position table: header byte, or phase and axis of a value byte
  function automatic pos_t pos_lookup(input logic [CNT_W-1:0] c);
    pos_t              p;
    logic [1:0]        ph;
    logic [AXIS_W-1:0] ax;
    p.is_hdr = (c < CNT_W'(HDR_BYTES));
    p.is_val = 1'b0;
    p.phase  = PH_LEAD;
    p.axis   = '0;
    ph       = 2'd0;
    ax       = '0;
    for (int i = 0; i < VALUE_BYTES; i++) begin
      if (c == CNT_W'(VALUE_FIRST + i)) begin
        p.is_val = 1'b1;
        p.phase  = phase_t'(ph);
        p.axis   = ax;
      end
      if (ph == 2'd2) begin
        ph = 2'd0;
        ax = ax + AXIS_W'(1);
      end else begin
        ph = ph + 2'd1;
      end
    end
    return p;
  endfunction

  // Two BCD nibbles to binary: hi*10 + lo, 0..165
  function automatic logic [7:0] bcd_pair(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'h0, b[3:0]};
  endfunction

endpackage

// ===== rtl/core/bcd_imu_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcd_imu_frame_parser_core: sign-magnitude BCD IMU reply frame parser
// Takes a reply frame byte by byte and emits six axis values per frame.
//
//   channel  | direction | tdata                          | tuser
//   in_      | slave     | rx_byte[7:0]                   | frame_start
//   out_     | master    | rate_x..accel_z, 19 bits each  | header_ok
//
// One byte per cycle sustained while no result is stalled; a byte sits in
// the input register while the decode logic works on it, and the result of
// the last frame byte is loaded into the output register when the decoder
// processes that byte.
// Sync active-low reset sets header match; clears count, flags, axis values.
// A stalled result blocks only the byte that closes the next frame.
// ---------------------------------------------------------------------------
module bcd_imu_frame_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  logic [0:0]   in_tuser,   // [0] frame_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // rate_x, rate_y, rate_z, accel_x, accel_y,
                                   // accel_z (19 bits each from bit 0), 0 pad
  output logic [0:0]   out_tuser   // [0] header_ok
);
  import bip_pkg::*;

  item_t       in_item;
  item_t       hold_item;
  logic        hold_valid;
  logic        take;
  logic        out_free;
  dec_status_t dec_status;
  result_t     dec_result;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_data_r;

  assign in_item.frame_start = in_tuser[0];
  assign in_item.rx_byte     = in_tdata;

  // Input register
  bip_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // Decoder
  bip_frame_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (take),
    .item   (hold_item),
    .status (dec_status),
    .result (dec_result)
  );

  // A byte proceeds unless it closes a frame while the result slot is busy
  assign out_free = !out_valid_r || out_tready;
  assign take     = hold_valid && (!dec_status.produces || out_free);

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && dec_status.produces) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && dec_status.produces) begin
      out_data_r <= dec_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r.accel_z, out_data_r.accel_y,
                       out_data_r.accel_x, out_data_r.rate_z,
                       out_data_r.rate_y, out_data_r.rate_x};
  assign out_tuser  = out_data_r.header_ok;

`ifndef NO_ASSERTIONS
  // Byte count saturates at the frame length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dec_status.count <= CNT_W'(FRAME_LENGTH))
    else $error("byte count beyond frame length");

  // A closing byte never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && dec_status.produces && out_valid_r && !out_tready))
    else $error("result overwritten while stalled");

  // A processed closing byte always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && dec_status.produces) |=> out_valid_r)
    else $error("closing byte lost its result");
`endif

endmodule

// ===== rtl/core/bip_in_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bip_in_stage: input register of the BCD IMU frame parser
// Holds one accepted byte until the decoder consumes it.
// ---------------------------------------------------------------------------
module bip_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bip_pkg::item_t in_item,
  input  logic           take,      // decoder consumes the held byte
  output logic           hold_valid,
  output bip_pkg::item_t hold_item
);
  import bip_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Ready when empty or when the held byte leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

// ===== rtl/core/bip_frame_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bip_frame_decode: frame state and per-byte decode
// Byte count, header check, sign-magnitude BCD accumulate, axis values.
// ---------------------------------------------------------------------------
module bip_frame_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,     // held byte is processed this cycle
  input  bip_pkg::item_t       item,
  output bip_pkg::dec_status_t status,
  output bip_pkg::result_t     result
);
  import bip_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hmatch_r, hmatch_nxt;
  logic             neg_r, neg_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [VAL_W-1:0] axis_r   [AXES];
  logic [VAL_W-1:0] axis_nxt [AXES];

  logic [CNT_W-1:0] c;
  logic             active;
  pos_t             pos;
  logic [7:0]       pair;
  logic [14:0]      mid_term;
  logic [MAG_W-1:0] top_term;
  logic [MAG_W-1:0] sum_mag;
  logic [VAL_W-1:0] signed_val;
  logic             hdr_eq;

  // Effective byte position
  assign c      = item.frame_start ? '0 : count_r;
  assign active = (c < CNT_W'(FRAME_LENGTH));
  assign pos    = pos_lookup(c);

  // Digit terms
  assign pair     = bcd_pair(item.rx_byte);
  assign mid_term = 15'(pair) * W_MID;
  assign top_term = MAG_W'(item.rx_byte[3:0]) * W_TOP;
  assign hdr_eq   = (item.rx_byte == hdr_byte(c[1:0]));

  always_comb begin
    sum_mag = mag_r;
    case (pos.phase)
      PH_MID:  sum_mag = mag_r + MAG_W'(mid_term);
      PH_LOW:  sum_mag = mag_r + MAG_W'(pair);
      default: sum_mag = top_term;
    endcase
  end

  assign signed_val = neg_r ? VAL_W'(-{1'b0, sum_mag}) : {1'b0, sum_mag};

  // Next state
  always_comb begin
    count_nxt  = count_r;
    hmatch_nxt = hmatch_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    for (int i = 0; i < AXES; i++) begin
      axis_nxt[i] = axis_r[i];
    end
    if (fire) begin
      count_nxt = c;
      if (active) begin
        count_nxt = c + CNT_W'(1);
        if (pos.is_hdr) begin
          hmatch_nxt = (c == '0) ? hdr_eq : (hmatch_r & hdr_eq);
        end else if (pos.is_val) begin
          mag_nxt = sum_mag;
          if (pos.phase == PH_LEAD) begin
            neg_nxt = (item.rx_byte >= NEG_MIN);
          end
          if (pos.phase == PH_LOW && hmatch_r) begin
            axis_nxt[pos.axis] = signed_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      hmatch_r <= 1'b1;
      neg_r    <= 1'b0;
      mag_r    <= '0;
      for (int i = 0; i < AXES; i++) begin
        axis_r[i] <= '0;
      end
    end else begin
      count_r  <= count_nxt;
      hmatch_r <= hmatch_nxt;
      neg_r    <= neg_nxt;
      mag_r    <= mag_nxt;
      for (int i = 0; i < AXES; i++) begin
        axis_r[i] <= axis_nxt[i];
      end
    end
  end

  // Status and result of the byte in process
  assign status.produces = (c == CNT_W'(FRAME_LENGTH - 1));
  assign status.count    = count_r;

  assign result.rate_x    = axis_nxt[0];
  assign result.rate_y    = axis_nxt[1];
  assign result.rate_z    = axis_nxt[2];
  assign result.accel_x   = axis_nxt[3];
  assign result.accel_y   = axis_nxt[4];
  assign result.accel_z   = axis_nxt[5];
  assign result.header_ok = hmatch_nxt;

endmodule
